// ----- sv/lzd_pkg.sv -----
// Shared constants, codes and helpers for the LZ77 token decompressor.
// No dependencies; compiled first.
package lzd_pkg;

   // History window and output packing
   localparam int HISTORY_DEPTH = 4096;
   localparam int LANES         = 8;
   localparam int ADDR_W        = $clog2(HISTORY_DEPTH);
   localparam int BW_W          = $clog2(HISTORY_DEPTH + 1);
   // subtractor width: covers 16-bit offsets and the fill count, plus a borrow bit
   localparam int CALC_W        = ((BW_W > 16) ? BW_W : 16) + 1;
   localparam int DATA_W        = 64;
   localparam int CNT_W         = 4;

   // Stream header
   localparam logic [31:0] MAGIC_WORD   = 32'h54504B01;
   localparam logic [7:0]  STORED_FLAG  = 8'h01;
   localparam logic [2:0]  MAGIC_BYTES  = 3'd4;

   // Token parser phases
   typedef enum logic [2:0] {
      PH_HEADER  = 3'd0,
      PH_TYPE    = 3'd1,
      PH_LITLEN  = 3'd2,
      PH_LITDATA = 3'd3,
      PH_OFFLO   = 3'd4,
      PH_OFFHI   = 3'd5,
      PH_MLEN    = 3'd6
   } phase_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_BAD_HEADER = 2'd1,
      ST_BAD_OFFSET = 2'd2,
      ST_TRUNCATED  = 2'd3
   } status_type;

   // Magic byte expected at header position idx (little-endian)
   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      return MAGIC_WORD[{idx, 3'b000} +: 8];
   endfunction

endpackage

// ----- sv/lzd_if.sv -----
// Valid/ready channel interfaces for the LZ77 token decompressor.
// No dependencies; compiled after lzd_pkg.

// Compressed byte stream, one byte per beat
interface lzd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       stream_last;

   modport source (output valid, output in_byte, output stream_last, input ready);
   modport sink   (input valid, input in_byte, input stream_last, output ready);
endinterface

// Decoded bytes, packed up to eight per beat
interface lzd_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] out_bytes;
   logic [3:0]  byte_count;
   logic        run_end;
   logic [1:0]  status;
   logic        stream_done;

   modport source (output valid, output out_bytes, output byte_count, output run_end,
                   output status, output stream_done, input ready);
   modport sink   (input valid, input out_bytes, input byte_count, input run_end,
                   input status, input stream_done, output ready);
endinterface

// ----- sv/lz77_token_decompressor.sv -----
// LZ77 token decompressor: header check, token parser, history copy engine.
// Depends on lzd_pkg and the channel interfaces in lzd_if.sv.
//
//   channel  | direction | beat carries
//   ---------+-----------+---------------------------------------------------
//   req_bus  | in        | in_byte, stream_last
//   rsp_bus  | out       | out_bytes, byte_count, run_end, status, stream_done
//
// Steps: a byte with no result is accepted, then decoded; a literal,
// pass-through, error or closing byte is accepted, decoded and sent. A match
// is decoded and set up, then each copied byte is a read step then a write step
// (the history RAM has one registered read port), with a send per packed beat.
// Reset is synchronous and clears all parse state except the copy source; the
// history RAM is not cleared. A stalled rsp_bus holds the block in its send step;
// one result can wait in the output register while the next byte is accepted.
module lz77_token_decompressor (
   input logic        clock,
   input logic        reset,
   lzd_req_if.sink    req_bus,
   lzd_rsp_if.source  rsp_bus
);
   import lzd_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_DECODE  = 6'b000010,
      S_SETUP   = 6'b000100,
      S_COPY_RD = 6'b001000,
      S_COPY_WR = 6'b010000,
      S_SEND    = 6'b100000
   } seq_type;

   localparam logic [ADDR_W-1:0] DEPTH_LOW = ADDR_W'(HISTORY_DEPTH);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(HISTORY_DEPTH - 1);
   localparam logic [BW_W-1:0]   BW_FULL   = BW_W'(HISTORY_DEPTH);
   localparam logic [CNT_W-1:0]  LANE_TOP  = CNT_W'(LANES - 1);

   // sequencer and latched input beat
   seq_type              state_ff, state_in;
   logic [7:0]           byte_ff, byte_in;
   logic                 last_ff, last_in;

   // parse state
   phase_type            phase_ff, phase_in;
   logic [2:0]           hidx_ff, hidx_in;
   logic                 hmatch_ff, hmatch_in;
   logic                 pass_ff, pass_in;
   logic [7:0]           rem_ff, rem_in;
   logic [15:0]          off_ff, off_in;
   logic [ADDR_W-1:0]    wp_ff, wp_in;
   logic [BW_W-1:0]      bw_ff, bw_in;
   logic                 sticky_ff, sticky_in;
   status_type           code_ff, code_in;
   logic [ADDR_W-1:0]    src_ff, src_in;

   // packing buffer
   logic [DATA_W-1:0]    pack_ff, pack_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 final_ff, final_in;

   // output register
   logic                 ovalid_ff, ovalid_in;
   logic [DATA_W-1:0]    obytes_ff, obytes_in;
   logic [CNT_W-1:0]     ocnt_ff, ocnt_in;
   logic                 orun_ff, orun_in;
   status_type           ostat_ff, ostat_in;
   logic                 odone_ff, odone_in;

   // history RAM
   logic [7:0]           hist_mem [HISTORY_DEPTH];
   logic [7:0]           rd_data_ff;
   logic                 mem_we, mem_re;
   logic [7:0]           mem_wdata;

   // shared subtractor
   logic [CALC_W-1:0]    sub_a, sub_b, sub_diff;
   logic                 sub_borrow;
   logic [ADDR_W-1:0]    src_calc, wp_inc, src_inc;
   logic [BW_W-1:0]      bw_inc;
   logic                 off_bad;

   // One subtractor: fill count minus offset while decoding, write pointer
   // minus offset when the copy source is set up.
   always_comb begin
      sub_a = (state_ff == S_SETUP) ? CALC_W'(wp_ff) : CALC_W'(bw_ff);
      sub_b = CALC_W'(off_ff);
   end
   assign sub_diff   = sub_a - sub_b;
   assign sub_borrow = sub_diff[CALC_W-1];
   assign off_bad    = (off_ff == 16'd0) || sub_borrow;
   assign src_calc   = sub_borrow ? (sub_diff[ADDR_W-1:0] + DEPTH_LOW) : sub_diff[ADDR_W-1:0];

   // wrapping pointers, saturating fill count
   assign wp_inc  = (wp_ff == LAST_ADDR) ? '0 : wp_ff + 1'b1;
   assign src_inc = (src_ff == LAST_ADDR) ? '0 : src_ff + 1'b1;
   assign bw_inc  = (bw_ff == BW_FULL) ? bw_ff : bw_ff + 1'b1;

   // Sequencer and parser
   always_comb begin
      logic       hmatch_nx;
      logic [7:0] rem_dec;
      logic       emit;
      logic       copy;
      status_type err;

      hmatch_nx = hmatch_ff;
      rem_dec   = rem_ff;
      emit      = 1'b0;
      copy      = 1'b0;
      err       = ST_OK;

      state_in  = state_ff;
      byte_in   = byte_ff;
      last_in   = last_ff;
      phase_in  = phase_ff;
      hidx_in   = hidx_ff;
      hmatch_in = hmatch_ff;
      pass_in   = pass_ff;
      rem_in    = rem_ff;
      off_in    = off_ff;
      wp_in     = wp_ff;
      bw_in     = bw_ff;
      sticky_in = sticky_ff;
      code_in   = code_ff;
      src_in    = src_ff;
      pack_in   = pack_ff;
      cnt_in    = cnt_ff;
      final_in  = final_ff;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_wdata = byte_ff;

      // output register drains on a taken beat
      ovalid_in = ovalid_ff && !rsp_bus.ready;
      obytes_in = obytes_ff;
      ocnt_in   = ocnt_ff;
      orun_in   = orun_ff;
      ostat_in  = ostat_ff;
      odone_in  = odone_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               byte_in  = req_bus.in_byte;
               last_in  = req_bus.stream_last;
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            if (!sticky_ff) begin
               if (pass_ff) begin
                  emit = 1'b1;
               end else begin
                  case (phase_ff)
                     PH_HEADER: begin
                        if (hidx_ff < MAGIC_BYTES) begin
                           hmatch_nx = hmatch_ff && (byte_ff == magic_byte(hidx_ff[1:0]));
                           hmatch_in = hmatch_nx;
                           if (hidx_ff == MAGIC_BYTES - 3'd1 && !hmatch_nx) begin
                              err = ST_BAD_HEADER;
                           end
                           hidx_in = hidx_ff + 3'd1;
                        end else begin
                           pass_in  = (byte_ff & STORED_FLAG) != 8'h00;
                           phase_in = PH_TYPE;
                        end
                     end
                     PH_TYPE: begin
                        phase_in = (byte_ff == 8'h00) ? PH_LITLEN : PH_OFFLO;
                     end
                     PH_LITLEN: begin
                        rem_in   = byte_ff;
                        phase_in = (byte_ff != 8'h00) ? PH_LITDATA : PH_TYPE;
                     end
                     PH_LITDATA: begin
                        mem_we  = 1'b1;
                        emit    = 1'b1;
                        wp_in   = wp_inc;
                        bw_in   = bw_inc;
                        rem_dec = (rem_ff != 8'h00) ? rem_ff - 8'd1 : rem_ff;
                        rem_in  = rem_dec;
                        if (rem_dec == 8'h00) begin
                           phase_in = PH_TYPE;
                        end
                     end
                     PH_OFFLO: begin
                        off_in   = {8'h00, byte_ff};
                        phase_in = PH_OFFHI;
                     end
                     PH_OFFHI: begin
                        off_in   = {byte_ff, off_ff[7:0]};
                        phase_in = PH_MLEN;
                     end
                     PH_MLEN: begin
                        phase_in = PH_TYPE;
                        if (byte_ff != 8'h00) begin
                           if (off_bad) begin
                              err = ST_BAD_OFFSET;
                           end else begin
                              rem_in = byte_ff;
                              copy   = 1'b1;
                           end
                        end
                     end
                     default: begin
                        phase_in = PH_TYPE;
                     end
                  endcase

                  // last byte with a token still open
                  if (last_ff && err == ST_OK && phase_in != PH_TYPE) begin
                     err = (phase_in == PH_HEADER) ? ST_BAD_HEADER : ST_TRUNCATED;
                  end
               end

               if (err != ST_OK) begin
                  sticky_in = 1'b1;
                  code_in   = err;
               end
            end

            if (emit) begin
               pack_in = DATA_W'(byte_ff);
               cnt_in  = CNT_W'(1);
            end
            final_in = 1'b1;

            if (copy) begin
               state_in = S_SETUP;
            end else if (emit || last_ff || err != ST_OK) begin
               state_in = S_SEND;
            end else begin
               state_in = S_IDLE;
            end
         end

         S_SETUP: begin
            src_in   = src_calc;
            state_in = S_COPY_RD;
         end

         S_COPY_RD: begin
            mem_re   = 1'b1;
            state_in = S_COPY_WR;
         end

         // write the fetched byte back at the head and pack it
         S_COPY_WR: begin
            mem_we    = 1'b1;
            mem_wdata = rd_data_ff;
            for (int i = 0; i < LANES; i++) begin
               if (cnt_ff == CNT_W'(i)) begin
                  pack_in[8*i +: 8] = rd_data_ff;
               end
            end
            cnt_in = cnt_ff + CNT_W'(1);
            rem_in = rem_ff - 8'd1;
            wp_in  = wp_inc;
            bw_in  = bw_inc;
            src_in = src_inc;
            if (cnt_ff == LANE_TOP || rem_ff == 8'd1) begin
               final_in = (rem_ff == 8'd1);
               state_in = S_SEND;
            end else begin
               state_in = S_COPY_RD;
            end
         end

         S_SEND: begin
            if (!ovalid_ff || rsp_bus.ready) begin
               ovalid_in = 1'b1;
               obytes_in = pack_ff;
               ocnt_in   = cnt_ff;
               orun_in   = final_ff;
               ostat_in  = code_ff;
               odone_in  = final_ff && last_ff;
               pack_in   = '0;
               cnt_in    = '0;
               if (final_ff) begin
                  state_in = S_IDLE;
                  // end of stream: parse state back to its reset value
                  if (last_ff) begin
                     phase_in  = PH_HEADER;
                     hidx_in   = 3'd0;
                     hmatch_in = 1'b1;
                     pass_in   = 1'b0;
                     rem_in    = 8'h00;
                     off_in    = 16'h0000;
                     wp_in     = '0;
                     bw_in     = '0;
                     sticky_in = 1'b0;
                     code_in   = ST_OK;
                  end
               end else begin
                  state_in = S_COPY_RD;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         last_ff   <= 1'b0;
         phase_ff  <= PH_HEADER;
         hidx_ff   <= 3'd0;
         hmatch_ff <= 1'b1;
         pass_ff   <= 1'b0;
         rem_ff    <= 8'h00;
         off_ff    <= 16'h0000;
         wp_ff     <= '0;
         bw_ff     <= '0;
         sticky_ff <= 1'b0;
         code_ff   <= ST_OK;
         pack_ff   <= '0;
         cnt_ff    <= '0;
         final_ff  <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         last_ff   <= last_in;
         phase_ff  <= phase_in;
         hidx_ff   <= hidx_in;
         hmatch_ff <= hmatch_in;
         pass_ff   <= pass_in;
         rem_ff    <= rem_in;
         off_ff    <= off_in;
         wp_ff     <= wp_in;
         bw_ff     <= bw_in;
         sticky_ff <= sticky_in;
         code_ff   <= code_in;
         pack_ff   <= pack_in;
         cnt_ff    <= cnt_in;
         final_ff  <= final_in;
         ovalid_ff <= ovalid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      src_ff    <= src_in;
      obytes_ff <= obytes_in;
      ocnt_ff   <= ocnt_in;
      orun_ff   <= orun_in;
      ostat_ff  <= ostat_in;
      odone_ff  <= odone_in;
   end

   // history RAM: one write port at the head, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[wp_ff] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= hist_mem[src_ff];
      end
   end

   assign req_bus.ready       = (state_ff == S_IDLE);
   assign rsp_bus.valid       = ovalid_ff;
   assign rsp_bus.out_bytes   = obytes_ff;
   assign rsp_bus.byte_count  = ocnt_ff;
   assign rsp_bus.run_end     = orun_ff;
   assign rsp_bus.status      = ostat_ff;
   assign rsp_bus.stream_done = odone_ff;

endmodule

// ----- sv/lzd_checker.sv -----
// Port-level checks for the LZ77 token decompressor, bound to the top level.
// Depends on lzd_pkg and lz77_token_decompressor.
module lzd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_out_bytes,
   input logic [3:0]  rsp_byte_count,
   input logic        rsp_run_end,
   input logic [1:0]  rsp_status,
   input logic        rsp_stream_done
);
   import lzd_pkg::*;

   // a beat never carries more bytes than there are lanes
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_byte_count <= CNT_W'(LANES))
      else $error("byte_count above lane count");

   // an empty beat is always the last one for its input byte
   a_empty_is_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_count == 4'd0 |-> rsp_run_end)
      else $error("empty beat without run_end");

   // the stream closes only on the last beat of a byte
   a_done_is_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stream_done |-> rsp_run_end)
      else $error("stream_done without run_end");

   // one byte at a time: no new input right after an accepted one
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken on consecutive cycles");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_bytes)
         && $stable(rsp_byte_count) && $stable(rsp_run_end)
         && $stable(rsp_status) && $stable(rsp_stream_done))
      else $error("stalled result beat changed");

endmodule

bind lz77_token_decompressor lzd_checker u_lzd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_out_bytes   (rsp_bus.out_bytes),
   .rsp_byte_count  (rsp_bus.byte_count),
   .rsp_run_end     (rsp_bus.run_end),
   .rsp_status      (rsp_bus.status),
   .rsp_stream_done (rsp_bus.stream_done)
);
